>>> rtl/core/lta_pkg.sv
// Shared types and constants for the packet airtime calculator.
package lta_pkg;

	localparam int LEN_W     = 8;
	localparam int SF_W      = 4;
	localparam int BW_W      = 14;
	localparam int CR_W      = 4;
	localparam int PRE_W     = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;
	localparam int AIR_W     = 24;

	localparam int SYM_NUM_W = 10;
	localparam int SYM_DEN_W = 4;
	localparam int PSYM_W    = 14;
	localparam int QSYM_W    = 19;
	localparam int AIR_NUM_W = 35;

	localparam int FIFO_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SF  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CR  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PRE = CFG_IDX_W'(3);

	localparam logic [SF_W-1:0]  SF_RESET  = SF_W'(11);
	localparam logic [BW_W-1:0]  BW_RESET  = BW_W'(2000);
	localparam logic [CR_W-1:0]  CR_RESET  = CR_W'(5);
	localparam logic [PRE_W-1:0] PRE_RESET = PRE_W'(16);

	localparam logic [AIR_W-1:0] AIR_MAX = {AIR_W{1'b1}};

	typedef struct packed {
		logic [SF_W-1:0]  sf;
		logic [BW_W-1:0]  bw8;
		logic [CR_W-1:0]  cr;
		logic [PRE_W-1:0] pre;
	} lta_cfg_t;

	typedef struct packed {
		logic                 ldro;
		logic [SYM_NUM_W-1:0] dividend;
		logic [SYM_DEN_W-1:0] divisor;
	} lta_item_t;

endpackage

>>> rtl/core/lora_time_on_air.sv
// Top level of the packet airtime calculator: configuration registers and pipeline.
// Usage:
//  Slave stream s_*: one word per packet, s_tdata[7:0] = payload length in bytes.
//  Master stream m_*: one word per packet, m_tdata[23:0] = airtime in whole ms,
//  saturated; m_tuser[0] = low data rate optimisation flag.
//  Configuration channel cfg_*: cfg_index selects spreading factor (0), bandwidth in
//  0.125 kHz units (1), coding denominator (2) or preamble length (3); other indexes
//  are dropped. cfg_ready is always high. Write only while no packet is in flight.
//  Path from s_tvalid & s_tready to m_tvalid: the front register, the queue, the
//  10-stage symbol divider, two sum stages, the 35-stage airtime divider and the
//  output register; the dividers resolve one quotient bit per stage.
//  Throughput: one word per cycle while the output is not held by m_tready.
//  Reset: configuration returns to sf 11, 250 kHz, 4/5, 16 preamble symbols; the
//  pipeline and queue empty.
//  When m_tready is low while an output word waits, the back end holds; the front end
//  keeps taking words into its queue until it fills, then s_tready drops.
module lora_time_on_air #(
	parameter int FIFO_DEPTH = lta_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] payload_length
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // [23:0] airtime_ms
	output logic [0:0]                      m_tuser,   // [0] low_rate_optimize
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lta_pkg::CFG_DAT_W-1:0]   cfg_data
);

	lta_pkg::lta_cfg_t  cfg_q;
	logic               f_valid;
	logic               f_ready;
	lta_pkg::lta_item_t f_item;
	logic               b_valid;
	logic               b_ready;
	lta_pkg::lta_item_t b_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sf  <= lta_pkg::SF_RESET;
			cfg_q.bw8 <= lta_pkg::BW_RESET;
			cfg_q.cr  <= lta_pkg::CR_RESET;
			cfg_q.pre <= lta_pkg::PRE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lta_pkg::REG_SF:  cfg_q.sf  <= cfg_data[lta_pkg::SF_W-1:0];
				lta_pkg::REG_BW:  cfg_q.bw8 <= cfg_data[lta_pkg::BW_W-1:0];
				lta_pkg::REG_CR:  cfg_q.cr  <= cfg_data[lta_pkg::CR_W-1:0];
				lta_pkg::REG_PRE: cfg_q.pre <= cfg_data[lta_pkg::PRE_W-1:0];
				default: ;
			endcase
		end
	end

	lta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_len     (s_tdata),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	lta_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	lta_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (b_valid),
		.item_ready  (b_ready),
		.item        (b_item),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_airtime (m_tdata),
		.out_ldro    (m_tuser[0])
	);

endmodule

>>> rtl/core/lta_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module lta_div #(
	parameter int NUM_W  = lta_pkg::SYM_NUM_W,
	parameter int DEN_W  = lta_pkg::SYM_DEN_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              valid_q [NUM_W];
	logic [NUM_W-1:0]  work_q  [NUM_W];
	logic [DEN_W-1:0]  rem_q   [NUM_W];
	logic [DEN_W-1:0]  den_q   [NUM_W];
	logic [SIDE_W-1:0] side_q  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              v_prev;
		logic [NUM_W-1:0]  w_prev;
		logic [DEN_W-1:0]  r_prev;
		logic [DEN_W-1:0]  d_prev;
		logic [SIDE_W-1:0] s_prev;
		logic [DEN_W:0]    trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_prev = in_valid;
			assign w_prev = in_num;
			assign r_prev = '0;
			assign d_prev = in_den;
			assign s_prev = in_side;
		end else begin : g_next
			assign v_prev = valid_q[k-1];
			assign w_prev = work_q[k-1];
			assign r_prev = rem_q[k-1];
			assign d_prev = den_q[k-1];
			assign s_prev = side_q[k-1];
		end

		assign trial = {r_prev, w_prev[NUM_W-1]};
		assign take  = (trial >= {1'b0, d_prev});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (en) begin
				valid_q[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_q[k] <= {w_prev[NUM_W-2:0], take};
				rem_q[k]  <= take ? DEN_W'(trial - {1'b0, d_prev}) : trial[DEN_W-1:0];
				den_q[k]  <= d_prev;
				side_q[k] <= s_prev;
			end
		end
	end

	assign out_valid = valid_q[NUM_W-1];
	assign out_quo   = work_q[NUM_W-1];
	assign out_side  = side_q[NUM_W-1];

endmodule

>>> rtl/core/lta_front.sv
// Front end: accept a length word, work out the symbol division operands.
module lta_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lta_pkg::lta_cfg_t           cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lta_pkg::LEN_W-1:0]   in_len,
	output logic                        item_valid,
	input  logic                        item_ready,
	output lta_pkg::lta_item_t          item
);

	logic               item_valid_s1;
	lta_pkg::lta_item_t item_s1;
	lta_pkg::lta_item_t item_d;
	logic [15:0]        chips;
	logic               ldro;
	logic signed [12:0] num;
	logic signed [5:0]  div_raw;
	logic [lta_pkg::SYM_DEN_W-1:0] div;
	logic [lta_pkg::SYM_NUM_W-1:0] n4;

	always_comb begin
		chips   = 16'(1) << cfg.sf;
		ldro    = (chips > {1'b0, cfg.bw8, 1'b0});
		num     = $signed({2'b00, in_len, 3'b000}) + 13'sd44
			- $signed({7'b0, cfg.sf, 2'b00});
		div_raw = $signed({2'b00, cfg.sf}) - (ldro ? 6'sd2 : 6'sd0);
		div     = (div_raw <= 6'sd0) ? lta_pkg::SYM_DEN_W'(1)
			: div_raw[lta_pkg::SYM_DEN_W-1:0];
		n4      = lta_pkg::SYM_NUM_W'((num + 13'sd3) >>> 2);
		item_d.ldro     = ldro;
		item_d.divisor  = div;
		item_d.dividend = (num > 13'sd0)
			? n4 + lta_pkg::SYM_NUM_W'(div) - lta_pkg::SYM_NUM_W'(1) : '0;
	end

	assign in_ready = !item_valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = item_valid_s1;
	assign item       = item_s1;

endmodule

>>> rtl/core/lta_fifo.sv
// Short register queue between the front and back ends.
module lta_fifo #(
	parameter int DEPTH = lta_pkg::FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  lta_pkg::lta_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output lta_pkg::lta_item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lta_pkg::lta_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q == CNT_W'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/lta_back.sv
// Back end: symbol division, quarter-symbol total, airtime division, output word.
module lta_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lta_pkg::lta_cfg_t         cfg,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  lta_pkg::lta_item_t        item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lta_pkg::AIR_W-1:0] out_airtime,
	output logic                      out_ldro
);

	logic en;
	logic sym_valid;
	logic [lta_pkg::SYM_NUM_W-1:0] sym_quo;
	logic sym_ldro;
	logic                        valid_s1;
	logic [lta_pkg::PSYM_W-1:0]  psym_s1;
	logic                        ldro_s1;
	logic                        valid_s2;
	logic [lta_pkg::AIR_NUM_W-1:0] dividend_s2;
	logic                        ldro_s2;
	logic [lta_pkg::QSYM_W-1:0]  qsym;
	logic                        air_valid;
	logic [lta_pkg::AIR_NUM_W-1:0] air_quo;
	logic [1:0]                  air_side;
	logic                        out_valid_q;
	logic [lta_pkg::AIR_W-1:0]   airtime_q;
	logic                        ldro_q;
	logic                        sat;

	assign en         = !out_valid_q || out_ready;
	assign item_ready = en;

	lta_div #(
		.NUM_W  (lta_pkg::SYM_NUM_W),
		.DEN_W  (lta_pkg::SYM_DEN_W),
		.SIDE_W (1)
	) u_sym_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.in_num    (item.dividend),
		.in_den    (item.divisor),
		.in_side   (item.ldro),
		.out_valid (sym_valid),
		.out_quo   (sym_quo),
		.out_side  (sym_ldro)
	);

	assign qsym = {1'b0, cfg.pre, 2'b00} + lta_pkg::QSYM_W'(17)
		+ lta_pkg::QSYM_W'({psym_s1, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= sym_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= air_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psym_s1     <= lta_pkg::PSYM_W'(8)
				+ lta_pkg::PSYM_W'(sym_quo) * lta_pkg::PSYM_W'(cfg.cr);
			ldro_s1     <= sym_ldro;
			dividend_s2 <= lta_pkg::AIR_NUM_W'(qsym)
				<< ({1'b0, cfg.sf} + (lta_pkg::SF_W + 1)'(1));
			ldro_s2     <= ldro_s1;
			airtime_q   <= sat ? lta_pkg::AIR_MAX : air_quo[lta_pkg::AIR_W-1:0];
			ldro_q      <= air_side[0];
		end
	end

	lta_div #(
		.NUM_W  (lta_pkg::AIR_NUM_W),
		.DEN_W  (lta_pkg::BW_W),
		.SIDE_W (2)
	) u_air_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.in_num    (dividend_s2),
		.in_den    (cfg.bw8),
		.in_side   ({(cfg.bw8 == '0), ldro_s2}),
		.out_valid (air_valid),
		.out_quo   (air_quo),
		.out_side  (air_side)
	);

	assign sat = air_side[1] || (|air_quo[lta_pkg::AIR_NUM_W-1:lta_pkg::AIR_W]);

	assign out_valid   = out_valid_q;
	assign out_airtime = airtime_q;
	assign out_ldro    = ldro_q;

	a_zero_bw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (cfg.bw8 == '0) |-> (airtime_q == lta_pkg::AIR_MAX) && ldro_q)
		else $error("zero bandwidth must saturate");
	a_ldro: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ldro_q == ((16'(1) << cfg.sf) > {1'b0, cfg.bw8, 1'b0}))
		else $error("low rate flag disagrees with configuration");

endmodule
